[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Same check, with a plain message about an invariant.
`define ASSERT_INV(lbl, clk, rst_n, expr) \
    `ASSERT_CLK(lbl, clk, rst_n, expr, "invariant violated")

`endif

[design/u16u8_pkg.sv]
// ----------------------------------------------------------------------------
// u16u8_pkg
// Types, constants and byte-encoding helpers for the UTF-16 to UTF-8 core.
// ----------------------------------------------------------------------------
`default_nettype none

package u16u8_pkg;

    localparam int UNIT_W = 16;
    localparam int CP_W   = 21;
    localparam int QUEUE_DEPTH_DEF = 4;

    // Top six bits of a surrogate code unit.
    localparam logic [5:0] HIGH_TAG = 6'b110110;   // 0xD800..0xDBFF
    localparam logic [5:0] LOW_TAG  = 6'b110111;   // 0xDC00..0xDFFF

    localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;

    // Encoded length minus one.
    typedef enum logic [1:0] {
        LEN_1 = 2'd0,
        LEN_2 = 2'd1,
        LEN_3 = 2'd2,
        LEN_4 = 2'd3
    } u16u8_len_t;

    // One code point queued for serialization.
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            run_last;
        logic            str_end;
    } u16u8_entry_t;

    function automatic u16u8_len_t utf8_len(input logic [CP_W-1:0] cp);
        u16u8_len_t l;
        if (cp[20:16] != 5'd0) begin
            l = LEN_4;
        end else if (cp[15:11] != 5'd0) begin
            l = LEN_3;
        end else if (cp[10:7] != 4'd0) begin
            l = LEN_2;
        end else begin
            l = LEN_1;
        end
        return l;
    endfunction

    // Byte idx (0 = lead) of the UTF-8 sequence of cp.
    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input u16u8_len_t len,
                                             input logic [1:0] idx);
        logic [1:0] grp;
        logic [5:0] bits;
        logic [7:0] b;
        grp = 2'(len) - idx;
        unique case (grp)
            2'd0: bits = cp[5:0];
            2'd1: bits = cp[11:6];
            2'd2: bits = cp[17:12];
            2'd3: bits = {3'd0, cp[20:18]};
        endcase
        if (idx == 2'd0) begin
            unique case (len)
                LEN_1: b = {1'b0, cp[6:0]};
                LEN_2: b = {3'b110, cp[10:6]};
                LEN_3: b = {4'b1110, cp[15:12]};
                LEN_4: b = {5'b11110, cp[20:18]};
            endcase
        end else begin
            b = {2'b10, bits};
        end
        return b;
    endfunction

endpackage

`default_nettype wire

[design/u16u8_front.sv]
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts code units, pairs surrogates and queues code points for encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [UNIT_W-1:0]   code_unit,
    input  wire logic                last_unit,
    input  wire logic                q_full,
    output logic                     q_push,
    output u16u8_entry_t             q_data
);

    logic         pend_valid_reg, pend_valid_next;
    logic [9:0]   pend_high_reg, pend_high_next;
    logic         second_valid_reg, second_valid_next;
    u16u8_entry_t second_reg, second_next;

    logic         accept;
    logic         is_high, is_low;
    logic         hold;
    logic         has_first, has_second;
    u16u8_entry_t first_e, unit_e, flush_e, pair_e;

    assign is_high  = (code_unit[15:10] == HIGH_TAG);
    assign is_low   = (code_unit[15:10] == LOW_TAG);
    assign hold     = is_high && !last_unit;
    assign s_tready = !second_valid_reg && !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        unit_e.cp       = {5'd0, code_unit};
        unit_e.run_last = 1'b1;
        unit_e.str_end  = last_unit;

        pair_e.cp       = SUPP_BASE + {1'b0, pend_high_reg, code_unit[9:0]};
        pair_e.run_last = 1'b1;
        pair_e.str_end  = last_unit;

        // held high flushed alone; it closes the run only if nothing follows
        flush_e.cp       = {5'd0, HIGH_TAG, pend_high_reg};
        flush_e.run_last = hold;
        flush_e.str_end  = 1'b0;

        has_first  = 1'b0;
        has_second = 1'b0;
        first_e    = unit_e;
        if (pend_valid_reg && is_low) begin
            has_first = 1'b1;
            first_e   = pair_e;
        end else if (pend_valid_reg) begin
            has_first  = 1'b1;
            first_e    = flush_e;
            has_second = !hold;
        end else begin
            has_first = !hold;
        end
    end

    always_comb begin
        pend_valid_next   = pend_valid_reg;
        pend_high_next    = pend_high_reg;
        second_valid_next = second_valid_reg;
        second_next       = second_reg;
        q_push            = 1'b0;
        q_data            = first_e;
        if (second_valid_reg) begin
            q_data = second_reg;
            if (!q_full) begin
                q_push            = 1'b1;
                second_valid_next = 1'b0;
            end
        end else if (accept) begin
            q_push          = has_first;
            pend_valid_next = hold && !(pend_valid_reg && is_low);
            pend_high_next  = code_unit[9:0];
            if (has_second) begin
                second_valid_next = 1'b1;
                second_next       = unit_e;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg   <= 1'b0;
            second_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg   <= pend_valid_next;
            second_valid_reg <= second_valid_next;
        end
        pend_high_reg <= pend_high_next;
        second_reg    <= second_next;
    end

endmodule

`default_nettype wire

[design/u16u8_fifo.sv]
// ----------------------------------------------------------------------------
// u16u8_fifo
// Small register queue of code point entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module u16u8_fifo
    import u16u8_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire u16u8_entry_t  push_data,
    output logic               full,
    input  wire logic          pop,
    output u16u8_entry_t       pop_data,
    output logic               empty
);

    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    u16u8_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == COUNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_CLK(a_no_overflow, aclk, aresetn, push |-> !full, "push into full queue")
    `ASSERT_CLK(a_no_underflow, aclk, aresetn, pop |-> !empty, "pop from empty queue")
    `ASSERT_INV(a_count_range, aclk, aresetn, count_reg <= COUNT_W'(DEPTH))

endmodule

`default_nettype wire

[design/u16u8_back.sv]
// ----------------------------------------------------------------------------
// u16u8_back
// Serializes queued code points into UTF-8 bytes, one byte per cycle while the output is ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_empty,
    input  wire u16u8_entry_t  q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_run_last,
    output logic               m_tlast
);

    logic          cur_valid_reg, cur_valid_next;
    u16u8_entry_t  cur_reg, cur_next;
    u16u8_len_t    cur_len_reg, cur_len_next;
    logic [1:0]    cur_idx_reg, cur_idx_next;
    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_data_reg, m_data_next;
    logic          m_run_reg, m_run_next;
    logic          m_end_reg, m_end_next;

    logic adv, emit, final_byte;

    assign adv        = !m_valid_reg || m_tready;
    assign emit       = adv && cur_valid_reg;
    assign final_byte = (cur_idx_reg == 2'(cur_len_reg));
    assign q_pop      = !q_empty && (!cur_valid_reg || (emit && final_byte));

    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        cur_len_next   = cur_len_reg;
        cur_idx_next   = cur_idx_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_run_next     = m_run_reg;
        m_end_next     = m_end_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            m_data_next  = utf8_byte(cur_reg.cp, cur_len_reg, cur_idx_reg);
            m_run_next   = cur_reg.run_last && final_byte;
            m_end_next   = cur_reg.str_end && final_byte;
            cur_idx_next = cur_idx_reg + 1'b1;
            if (final_byte) begin
                cur_valid_next = 1'b0;
            end
        end
        if (q_pop) begin
            cur_valid_next = 1'b1;
            cur_next       = q_data;
            cur_len_next   = utf8_len(q_data.cp);
            cur_idx_next   = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        cur_reg     <= cur_next;
        cur_len_reg <= cur_len_next;
        cur_idx_reg <= cur_idx_next;
        m_data_reg  <= m_data_next;
        m_run_reg   <= m_run_next;
        m_end_reg   <= m_end_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_run_last = m_run_reg;
    assign m_tlast    = m_end_reg;

    `ASSERT_CLK(a_end_closes_run, aclk, aresetn, (m_valid_reg && m_end_reg) |-> m_run_reg,
        "string end without run end")
    `ASSERT_CLK(a_idx_in_seq, aclk, aresetn, cur_valid_reg |-> (cur_idx_reg <= 2'(cur_len_reg)),
        "byte index past sequence length")
    `ASSERT_CLK(a_ascii_len, aclk, aresetn,
        (cur_valid_reg && cur_len_reg == LEN_1) |-> (cur_reg.cp[20:7] == 14'd0),
        "single-byte length on non-ASCII code point")

endmodule

`default_nettype wire

[design/utf16_to_utf8_transcoder_core.sv]
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_core
// Streaming UTF-16 to UTF-8 transcoder with surrogate pairing.
// ----------------------------------------------------------------------------
// Each input transfer carries one UTF-16 code unit (tdata) and an end-of-string
// flag (tlast). Each output transfer carries one UTF-8 byte; m_tuser[0] marks
// the final byte caused by an input unit and m_tlast the final byte of the
// string. The output runs at one byte per cycle while m_tready is high and
// entries are queued. A BMP unit makes 1 to 3 bytes, a surrogate pair 4
// (spread over two units, the high unit itself makes none), and up to 6 come
// out when a held high surrogate that is not followed by a low one is flushed
// ahead of the next unit. The byte serializer in the back end sets this rate;
// the front end accepts one unit per cycle while the entry queue has room, and
// stalls intake while it queues the second entry of a flush-plus-unit case.
// Lone low surrogates, unpaired highs and a high that ends a string are encoded
// as three-byte sequences of their own value. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module utf16_to_utf8_transcoder_core
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF   // code point entries in flight
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // input units
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,    // [15:0] code_unit
    input  wire logic        s_tlast,    // last_unit

    // output bytes
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,    // [7:0] out_byte
    output logic [0:0]       m_tuser,    // [0] run_last
    output logic             m_tlast     // string_end
);

    logic          q_push, q_pop, q_full, q_empty;
    u16u8_entry_t  q_wdata, q_rdata;
    logic          run_last;

    // Front: surrogate pairing and pending-high state, one entry per code point.
    u16u8_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .code_unit (s_tdata),
        .last_unit (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // Queue decouples unit intake from byte output.
    u16u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // Back: one byte per cycle into the output register while m_tready allows.
    u16u8_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .q_data     (q_rdata),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_run_last (run_last),
        .m_tlast    (m_tlast)
    );

    assign m_tuser[0] = run_last;

endmodule

`default_nettype wire
